### hdl/bitmap_next_fit_slot_allocator_assert.svh
// Assertion macros shared by the slot allocator RTL.
`ifndef BITMAP_NEXT_FIT_SLOT_ALLOCATOR_ASSERT_SVH
`define BITMAP_NEXT_FIT_SLOT_ALLOCATOR_ASSERT_SVH

// Checks a property at every rising edge of clk_i, off while rst_ni is low.
`define BNFSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle implies a consequence in the next.
`define BNFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/bnfsa_pkg.sv
// Types, constants and codes of the bitmap next-fit slot allocator.
package bnfsa_pkg;

  localparam int SlotsPerChunk = 32;
  localparam int MaxChunks     = 8;
  localparam int SlotSpace     = 256;
  localparam int CountCap      = 15;

  // Chunks that can ever be active: one used-map word is kept per chunk.
  localparam int NumWordsA = (MaxChunks < CountCap) ? MaxChunks : CountCap;
  localparam int NumWords  = (NumWordsA < SlotSpace / SlotsPerChunk) ?
                             NumWordsA : SlotSpace / SlotsPerChunk;

  localparam int SlotW = 8;
  localparam int ObjW  = 13;
  localparam int OffW  = 20;
  localparam int ActW  = 4;
  localparam int WordW = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int PosW  = (SlotsPerChunk > 1) ? $clog2(SlotsPerChunk) : 1;
  localparam int CntW  = $clog2(NumWords + 1);

  localparam logic [ObjW-1:0]  ObjBytesReset = ObjW'(8);
  localparam logic [SlotW-1:0] LastSlotReset = SlotW'(SlotsPerChunk - 1);
  localparam logic [ActW-1:0]  ActiveReset   = ActW'(1);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_ALLOC = 2'd0,
    STAT_FREED = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic             command;
    logic [SlotW-1:0] slot_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [SlotW-1:0] granted_slot;
    logic [OffW-1:0]  byte_offset;
    logic [ActW-1:0]  chunks_in_use;
  } result_t;

  // Outcome of searching one used-map word for a free slot.
  typedef struct packed {
    logic            hit;
    logic [PosW-1:0] pos;
  } scan_res_t;

endpackage

### hdl/bnfsa_word_scan.sv
// Finds the lowest free slot of one used-map word inside a window around a start bit.
module bnfsa_word_scan
  import bnfsa_pkg::*;
(
  input  logic [SlotsPerChunk-1:0] word_i,
  input  logic [PosW-1:0]          lo_i,
  input  logic                     first_i,
  input  logic                     last_i,
  output scan_res_t                res_o
);

  logic [SlotsPerChunk-1:0] cand;

  // On the first word only bits at or above the start count, on the wrap-around
  // visit of the same word only bits below it.
  always_comb begin
    for (int b = 0; b < SlotsPerChunk; b++) begin
      cand[b] = !word_i[b] &&
                (!first_i || (PosW'(b) >= lo_i)) &&
                (!last_i  || (PosW'(b) <  lo_i));
    end
  end

  always_comb begin
    res_o.hit = |cand;
    res_o.pos = '0;
    for (int b = SlotsPerChunk - 1; b >= 0; b--) begin
      if (cand[b]) begin
        res_o.pos = PosW'(b);
      end
    end
  end

endmodule

### hdl/bitmap_next_fit_slot_allocator.sv
// Next-fit slot allocator over a used-slot bitmap, one word per chunk, scanned word by word.
//
// A command word is taken when start_i is high and busy_o is low. A free command
// goes from S_IDLE to S_MUL; an allocate command first passes through S_SCAN,
// which visits from 1 up to the number of active chunks plus one used-map words,
// and then S_MUL. The scan reads one chunk word per cycle from the bitmap, and
// S_MUL registers the byte offset from the slot-times-size multiplier. Each
// result word is shown for exactly one cycle with result_valid_o; the receiver
// cannot stall it, and a new command may be started in that same cycle. The user
// must write object_bytes through cfg_we_i/cfg_wdata_i only while the block is idle;
// the block itself does not enforce this.
`include "bitmap_next_fit_slot_allocator_assert.svh"

module bitmap_next_fit_slot_allocator
  import bnfsa_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  cmd_t            cmd_i,
  output logic            busy_o,
  input  logic            cfg_we_i,
  input  logic [ObjW-1:0] cfg_wdata_i,
  output logic            result_valid_o,
  output result_t         result_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_MUL  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [SlotsPerChunk-1:0] map_q [NumWords];
  logic [SlotW-1:0]         last_q;
  logic [ActW-1:0]          active_q;
  logic [ObjW-1:0]          obj_q;
  logic [WordW-1:0]         w_q, w_d;
  logic [PosW-1:0]          lo_q, lo_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [SlotW-1:0]         slot_q, slot_d;
  logic [1:0]               stat_q, stat_d;
  logic                     valid_q;
  result_t                  result_q;

  logic                     accept;
  logic [SlotW:0]           n_slots;
  logic [SlotW:0]           st_raw;
  logic [SlotW:0]           st;
  logic                     last_pass;
  logic                     can_grow;
  scan_res_t                scan;
  logic [SlotW+ObjW-1:0]    prod;

  logic                     map_we;
  logic [WordW-1:0]         map_word;
  logic [PosW-1:0]          map_pos;
  logic                     map_val;
  logic                     last_we;
  logic                     active_inc;

  assign accept    = start_i && (state_q == S_IDLE);
  assign n_slots   = (SlotW+1)'(32'(active_q) * SlotsPerChunk);
  assign st_raw    = {1'b0, last_q} + (SlotW+1)'(1);
  assign st        = (st_raw >= n_slots) ? '0 : st_raw;
  assign last_pass = (ActW'(cnt_q) == active_q);
  assign can_grow  = (32'(active_q) < NumWords);
  assign prod      = slot_q * obj_q;

  bnfsa_word_scan u_scan (
    .word_i  (map_q[w_q]),
    .lo_i    (lo_q),
    .first_i (cnt_q == '0),
    .last_i  (last_pass),
    .res_o   (scan)
  );

  always_comb begin
    state_d    = state_q;
    w_d        = w_q;
    lo_d       = lo_q;
    cnt_d      = cnt_q;
    slot_d     = slot_q;
    stat_d     = stat_q;
    map_we     = 1'b0;
    map_word   = '0;
    map_pos    = '0;
    map_val    = 1'b0;
    last_we    = 1'b0;
    active_inc = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_i.command == CMD_FREE) begin
            slot_d  = cmd_i.slot_index;
            state_d = S_MUL;
            if ({1'b0, cmd_i.slot_index} < n_slots) begin
              map_we   = 1'b1;
              map_word = WordW'(cmd_i.slot_index / SlotsPerChunk);
              map_pos  = PosW'(cmd_i.slot_index % SlotsPerChunk);
              stat_d   = STAT_FREED;
            end else begin
              stat_d = STAT_RANGE;
            end
          end else begin
            w_d     = WordW'(st / SlotsPerChunk);
            lo_d    = PosW'(st % SlotsPerChunk);
            cnt_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan.hit) begin
          slot_d   = SlotW'(32'(w_q) * SlotsPerChunk + 32'(scan.pos));
          map_we   = 1'b1;
          map_word = w_q;
          map_pos  = scan.pos;
          map_val  = 1'b1;
          last_we  = 1'b1;
          stat_d   = STAT_ALLOC;
          state_d  = S_MUL;
        end else if (last_pass) begin
          state_d = S_MUL;
          if (can_grow) begin
            // Every active slot is used: open the next chunk and take its first slot.
            slot_d     = SlotW'(n_slots);
            map_we     = 1'b1;
            map_word   = WordW'(active_q);
            map_pos    = '0;
            map_val    = 1'b1;
            last_we    = 1'b1;
            active_inc = 1'b1;
            stat_d     = STAT_ALLOC;
          end else begin
            slot_d = '0;
            stat_d = STAT_FULL;
          end
        end else begin
          w_d   = (ActW'(w_q) + ActW'(1) == active_q) ? '0 : w_q + WordW'(1);
          cnt_d = cnt_q + CntW'(1);
        end
      end
      S_MUL: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      last_q   <= LastSlotReset;
      active_q <= ActiveReset;
      obj_q    <= ObjBytesReset;
      valid_q  <= 1'b0;
      for (int i = 0; i < NumWords; i++) begin
        map_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == S_MUL);
      if (cfg_we_i) begin
        obj_q <= cfg_wdata_i;
      end
      if (map_we) begin
        map_q[map_word][map_pos] <= map_val;
      end
      if (last_we) begin
        last_q <= slot_d;
      end
      if (active_inc) begin
        active_q <= active_q + ActW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    lo_q   <= lo_d;
    cnt_q  <= cnt_d;
    slot_q <= slot_d;
    stat_q <= stat_d;
    if (state_q == S_MUL) begin
      result_q.status        <= stat_q;
      result_q.granted_slot  <= slot_q;
      result_q.byte_offset   <= prod[OffW-1:0];
      result_q.chunks_in_use <= active_q;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign result_o       = result_q;

  `BNFSA_ASSERT_NEXT(a_accept_busy, accept, busy_o, "busy must rise after a command word is taken")
  `BNFSA_ASSERT_NEXT(a_single_strobe, result_valid_o, !result_valid_o, "result strobe lasted more than one cycle")
  `BNFSA_ASSERT(a_full_zero, !(result_valid_o && (result_o.status == STAT_FULL)) || (result_o.granted_slot == '0), "full result must carry slot zero")
  `BNFSA_ASSERT(a_active_range, (active_q != '0) && (32'(active_q) <= NumWords), "active chunk count out of range")

endmodule

### verif/bitmap_next_fit_slot_allocator_test.sv
// Self-checking testbench for the bitmap next-fit slot allocator, with a directed table and random phases.
module bitmap_next_fit_slot_allocator_test;
  import bnfsa_pkg::*;

  localparam int CycleLimit = 200000;

  typedef struct packed {
    logic            is_cfg;
    logic            typed;
    cmd_t            word;
    logic [15:0]     reps;
    logic [ObjW-1:0] obj;
    result_t         want;
  } step_t;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            start_i;
  cmd_t            cmd_i;
  logic            busy_o;
  logic            cfg_we_i;
  logic [ObjW-1:0] cfg_wdata_i;
  logic            result_valid_o;
  result_t         result_o;

  // Shadow copy of the allocator state.
  logic [SlotSpace-1:0] model_used;
  logic [SlotW-1:0]     model_last;
  logic [ActW-1:0]      model_chunks;
  logic [ObjW-1:0]      model_obj;

  result_t     expected_grants[$];
  result_t     want_word;
  step_t       plan[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;

  bitmap_next_fit_slot_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .cmd_i         (cmd_i),
    .busy_o        (busy_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic result_t predict_grant(input cmd_t w);
    result_t     r;
    int unsigned n;
    int unsigned s;
    int unsigned k;
    int unsigned prod;
    bit          found;
    r = '0;
    found = 1'b0;
    n = model_chunks * SlotsPerChunk;
    if (n > SlotSpace) n = SlotSpace;
    if (w.command == CMD_ALLOC) begin
      s = model_last;
      for (k = 0; k < n && !found; k++) begin
        s = s + 1;
        if (s >= n) s = 0;
        found = !model_used[s];
      end
      // Growth only when every active slot is taken.
      if (!found && model_chunks < MaxChunks && model_chunks < CountCap &&
          (model_chunks + 1) * SlotsPerChunk <= SlotSpace) begin
        s = n;
        model_chunks = model_chunks + 1'b1;
        found = 1'b1;
      end
      if (found) begin
        model_used[s] = 1'b1;
        model_last = s[SlotW-1:0];
        r.granted_slot = s[SlotW-1:0];
        r.status = STAT_ALLOC;
      end else begin
        r.status = STAT_FULL;
      end
    end else begin
      r.granted_slot = w.slot_index;
      if (w.slot_index < n) begin
        model_used[w.slot_index] = 1'b0;
        r.status = STAT_FREED;
      end else begin
        r.status = STAT_RANGE;
      end
    end
    prod = 32'(r.granted_slot) * 32'(model_obj);
    r.byte_offset = prod[OffW-1:0];
    r.chunks_in_use = model_chunks;
    return r;
  endfunction

  function automatic step_t plain_row(input cmd_e c, input logic [SlotW-1:0] s,
                                      input int unsigned reps);
    step_t t;
    t = '0;
    t.word.command = c;
    t.word.slot_index = s;
    t.reps = reps[15:0];
    return t;
  endfunction

  function automatic step_t checked_row(input cmd_e c, input logic [SlotW-1:0] s,
                                        input status_e st, input logic [SlotW-1:0] g,
                                        input logic [OffW-1:0] off,
                                        input logic [ActW-1:0] ch);
    step_t t;
    t = plain_row(c, s, 1);
    t.typed = 1'b1;
    t.want.status = st;
    t.want.granted_slot = g;
    t.want.byte_offset = off;
    t.want.chunks_in_use = ch;
    return t;
  endfunction

  function automatic step_t cfg_row(input logic [ObjW-1:0] v);
    step_t t;
    t = '0;
    t.is_cfg = 1'b1;
    t.obj = v;
    return t;
  endfunction

  // Holds start until the word is taken, then books its expected result.
  task automatic issue(input cmd_t w, input logic typed, input result_t want);
    result_t guess;
    start_i <= 1'b1;
    cmd_i <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    guess = predict_grant(w);
    expected_grants.push_back(typed ? want : guess);
  endtask

  task automatic pace();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_obj(input logic [ObjW-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    model_obj = v;
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_grants.size() == 0) begin
        $error("unexpected result word: status %0d slot %0d", result_o.status,
               result_o.granted_slot);
        mismatch_count++;
      end else begin
        want_word = expected_grants.pop_front();
        if (result_o.status !== want_word.status) begin
          $error("status: expected %0d, got %0d", want_word.status, result_o.status);
          mismatch_count++;
        end
        if (result_o.granted_slot !== want_word.granted_slot) begin
          $error("granted_slot: expected %0d, got %0d", want_word.granted_slot,
                 result_o.granted_slot);
          mismatch_count++;
        end
        if (result_o.byte_offset !== want_word.byte_offset) begin
          $error("byte_offset: expected %0d, got %0d", want_word.byte_offset,
                 result_o.byte_offset);
          mismatch_count++;
        end
        if (result_o.chunks_in_use !== want_word.chunks_in_use) begin
          $error("chunks_in_use: expected %0d, got %0d", want_word.chunks_in_use,
                 result_o.chunks_in_use);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    step_t       row;
    cmd_t        w;
    int unsigned r;
    int unsigned ph;
    int unsigned k;
    int unsigned alloc_pct;
    int unsigned top;
    logic [ObjW-1:0] obj;

    rst_ni = 1'b0;
    start_i <= 1'b0;
    cmd_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    model_used = '0;
    model_last = LastSlotReset;
    model_chunks = ActiveReset;
    model_obj = ObjBytesReset;

    // Reset values, out-of-range frees, refill of a lone free last slot, growth,
    // offset wrap with the widest size, and the full chunk limit.
    plan.push_back(checked_row(CMD_ALLOC, 8'h00, STAT_ALLOC, 8'd0, 20'd0, 4'd1));
    plan.push_back(checked_row(CMD_FREE, 8'd0, STAT_FREED, 8'd0, 20'd0, 4'd1));
    plan.push_back(checked_row(CMD_FREE, 8'd0, STAT_FREED, 8'd0, 20'd0, 4'd1));
    plan.push_back(checked_row(CMD_FREE, 8'd255, STAT_RANGE, 8'd255, 20'd2040, 4'd1));
    plan.push_back(checked_row(CMD_FREE, 8'd32, STAT_RANGE, 8'd32, 20'd256, 4'd1));
    plan.push_back(checked_row(CMD_ALLOC, 8'hFF, STAT_ALLOC, 8'd1, 20'd8, 4'd1));
    plan.push_back(plain_row(CMD_ALLOC, 8'hFF, 30));
    plan.push_back(checked_row(CMD_ALLOC, 8'h00, STAT_ALLOC, 8'd0, 20'd0, 4'd1));
    plan.push_back(checked_row(CMD_FREE, 8'd0, STAT_FREED, 8'd0, 20'd0, 4'd1));
    plan.push_back(checked_row(CMD_ALLOC, 8'h00, STAT_ALLOC, 8'd0, 20'd0, 4'd1));
    plan.push_back(checked_row(CMD_ALLOC, 8'h00, STAT_ALLOC, 8'd32, 20'd256, 4'd2));
    plan.push_back(checked_row(CMD_FREE, 8'd32, STAT_FREED, 8'd32, 20'd256, 4'd2));
    plan.push_back(checked_row(CMD_FREE, 8'd63, STAT_FREED, 8'd63, 20'd504, 4'd2));
    plan.push_back(checked_row(CMD_FREE, 8'd64, STAT_RANGE, 8'd64, 20'd512, 4'd2));
    plan.push_back(cfg_row(13'd4096));
    plan.push_back(checked_row(CMD_ALLOC, 8'h00, STAT_ALLOC, 8'd33, 20'd135168, 4'd2));
    plan.push_back(cfg_row(13'd8191));
    plan.push_back(checked_row(CMD_FREE, 8'd255, STAT_RANGE, 8'd255, 20'd1040129, 4'd2));
    plan.push_back(cfg_row(13'd0));
    plan.push_back(checked_row(CMD_ALLOC, 8'h00, STAT_ALLOC, 8'd34, 20'd0, 4'd2));
    plan.push_back(cfg_row(13'd1));
    plan.push_back(plain_row(CMD_ALLOC, 8'hAA, 300));
    plan.push_back(checked_row(CMD_ALLOC, 8'h00, STAT_FULL, 8'd0, 20'd0, 4'd8));
    plan.push_back(checked_row(CMD_FREE, 8'd200, STAT_FREED, 8'd200, 20'd200, 4'd8));
    plan.push_back(checked_row(CMD_ALLOC, 8'h00, STAT_ALLOC, 8'd200, 20'd200, 4'd8));
    plan.push_back(checked_row(CMD_FREE, 8'd255, STAT_FREED, 8'd255, 20'd255, 4'd8));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        write_obj(row.obj);
      end else begin
        for (r = 0; r < row.reps; r++) begin
          issue(row.word, row.typed, row.want);
          pace();
        end
      end
    end

    // Random phases: each picks a size, an allocate share and whether gaps occur.
    for (ph = 0; ph < 12; ph++) begin
      case (ph)
        0: obj = 13'd4096;
        1: obj = 13'd1;
        2: obj = 13'd8191;
        3: obj = 13'd0;
        default: obj = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 8191)) :
                                                     13'($urandom_range(1, 4096));
      endcase
      write_obj(obj);
      alloc_pct = $urandom_range(10, 90);
      gaps_on = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      for (k = 0; k < 62; k++) begin
        w.slot_index = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < alloc_pct) begin
          w.command = CMD_ALLOC;
        end else begin
          w.command = CMD_FREE;
          top = model_chunks * SlotsPerChunk;
          if (top > SlotSpace) top = SlotSpace;
          if ($urandom_range(0, 99) < 85) w.slot_index = 8'($urandom_range(0, top - 1));
        end
        issue(w, 1'b0, '0);
        pace();
      end
    end

    drain();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && expected_grants.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/bnfsa_pkg.sv
hdl/bnfsa_word_scan.sv
hdl/bitmap_next_fit_slot_allocator.sv
verif/bitmap_next_fit_slot_allocator_test.sv
